>>> hw/rtl/signed_int_to_custom_radix_text_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the radix text converter
// ---------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_CUSTOM_RADIX_TEXT_TOP_ASSERT_SVH
`define SIGNED_INT_TO_CUSTOM_RADIX_TEXT_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define SIRT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define SIRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/sirt_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sirt_pkg
// Shared widths, character codes and divider handshake types.
// ---------------------------------------------------------------------------
package sirt_pkg;

    localparam int MAX_SYMBOLS = 128;
    localparam int TBL_AW      = 7;
    localparam int DIGIT_DEPTH = 32;
    localparam int STK_AW      = 5;
    localparam int CNT_W       = 6;
    localparam int DIGIT_W     = 7;
    localparam int NUM_W       = 32;
    localparam int CHAR_W      = 8;
    localparam int LEN_W       = 8;
    localparam int DIV_STEPS   = 32;
    localparam int DIV_CW      = 5;

    localparam logic [CHAR_W-1:0] SYM_MIN  = 8'd33;
    localparam logic [CHAR_W-1:0] SYM_MAX  = 8'd126;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [LEN_W-1:0]  MIN_LEN  = 8'd2;

    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_CONVERT = 1'b1;

    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  dividend;
        logic [LEN_W-1:0]  divisor;
    } sirt_div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [NUM_W-1:0]  quot;
        logic [LEN_W-1:0]  rem;
    } sirt_div_rsp_t;

endpackage

>>> hw/rtl/signed_int_to_custom_radix_text_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// signed_int_to_custom_radix_text_top
// Signed 32-bit integer to text in a radix given by a loaded symbol table.
// ---------------------------------------------------------------------------
// A load beat writes one symbol. A convert beat first walks the symbol
// table through its single read port, reading and then checking each symbol
// in use, then runs the bit-serial divider once per digit, then fetches each
// character from the digit stack and the table, plus any output stall; a
// negative value adds one beat for the sign. The input is not ready until
// the last character has been loaded into the output register. An invalid
// base ends the convert beat without output.
// ---------------------------------------------------------------------------
`include "signed_int_to_custom_radix_text_top_assert.svh"

module signed_int_to_custom_radix_text_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [sirt_pkg::LEN_W-1:0]         cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               req_type,
    input  logic [sirt_pkg::TBL_AW-1:0]        sym_index,
    input  logic [sirt_pkg::CHAR_W-1:0]        sym_char,
    input  logic signed [sirt_pkg::NUM_W-1:0]  number,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [sirt_pkg::CHAR_W-1:0]        out_char,
    output logic                               last_char
);
    import sirt_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHK_RD,
        ST_CHK_CMP,
        ST_SIGN,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_POP_RD,
        ST_TBL_RD,
        ST_ZERO_RD,
        ST_EMIT
    } state_t;

    state_t            state_reg, state_next;
    logic [LEN_W-1:0]  base_len_reg, base_len_next;
    logic [LEN_W-1:0]  scan_reg, scan_next;
    logic [NUM_W-1:0]  mag_reg, mag_next;
    logic              neg_reg, neg_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic              last_char_reg, last_char_next;

    logic [CHAR_W-1:0]  sym_mem [MAX_SYMBOLS];
    logic [CHAR_W-1:0]  tbl_q;
    logic [TBL_AW-1:0]  tbl_raddr;
    logic [DIGIT_W-1:0] stk_mem [DIGIT_DEPTH];
    logic [DIGIT_W-1:0] stk_q;
    logic [STK_AW-1:0]  stk_raddr;

    logic              in_fire;
    logic              slot_free;
    logic              len_ok;
    logic [NUM_W-1:0]  num_u;
    logic [LEN_W-1:0]  scan_inc;
    logic              out_load;
    logic              out_last_d;
    logic [CHAR_W-1:0] out_char_d;
    logic              chk_clr;
    logic              chk_upd;
    logic              sym_bad;
    sirt_div_req_t     div_req;
    sirt_div_rsp_t     div_rsp;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign num_u     = number;
    assign scan_inc  = scan_reg + LEN_W'(1);
    assign len_ok    = (base_len_reg >= MIN_LEN)
                    && ({1'b0, base_len_reg} <= (LEN_W + 1)'(MAX_SYMBOLS));
    assign stk_raddr = STK_AW'(cnt_reg - CNT_W'(1));

    always_comb
    begin
        case (state_reg)
            ST_CHK_RD: tbl_raddr = scan_reg[TBL_AW-1:0];
            ST_TBL_RD: tbl_raddr = stk_q;
            default:   tbl_raddr = '0;
        endcase
    end

    sirt_sym_check u_sym_check
    (
        .clk   (clk),
        .rst_n (rst_n),
        .clr   (chk_clr),
        .upd   (chk_upd),
        .sym   (tbl_q),
        .bad   (sym_bad)
    );

    sirt_divider u_divider
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // symbol table: every 7-bit index lies inside the table
    always_ff @(posedge clk)
    begin
        if (in_fire && (req_type == REQ_LOAD))
        begin
            sym_mem[sym_index] <= sym_char;
        end
        // hold the fetched symbol while the output beat waits
        if (state_reg != ST_EMIT)
        begin
            tbl_q <= sym_mem[tbl_raddr];
        end
    end

    // digit stack: push remainders least significant first, pop in reverse
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_DIV_WAIT) && div_rsp.done)
        begin
            stk_mem[cnt_reg[STK_AW-1:0]] <= div_rsp.rem[DIGIT_W-1:0];
        end
        stk_q <= stk_mem[stk_raddr];
    end

    always_comb
    begin
        state_next    = state_reg;
        base_len_next = base_len_reg;
        scan_next     = scan_reg;
        mag_next      = mag_reg;
        neg_next      = neg_reg;
        cnt_next      = cnt_reg;
        chk_clr       = 1'b0;
        chk_upd       = 1'b0;
        out_load      = 1'b0;
        out_char_d    = tbl_q;
        out_last_d    = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = mag_reg;
        div_req.divisor  = base_len_reg;

        if (cfg_we)
        begin
            base_len_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (req_type == REQ_CONVERT) && len_ok)
                begin
                    chk_clr    = 1'b1;
                    scan_next  = '0;
                    neg_next   = num_u[NUM_W-1];
                    mag_next   = num_u[NUM_W-1] ? (NUM_W'(0) - num_u) : num_u;
                    state_next = ST_CHK_RD;
                end
            end
            ST_CHK_RD:
            begin
                state_next = ST_CHK_CMP;
            end
            ST_CHK_CMP:
            begin
                if (sym_bad)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    chk_upd   = 1'b1;
                    scan_next = scan_inc;
                    if (scan_inc == base_len_reg)
                    begin
                        cnt_next = '0;
                        if (mag_reg == '0)
                        begin
                            state_next = ST_ZERO_RD;
                        end
                        else if (neg_reg)
                        begin
                            state_next = ST_SIGN;
                        end
                        else
                        begin
                            state_next = ST_DIV_GO;
                        end
                    end
                    else
                    begin
                        state_next = ST_CHK_RD;
                    end
                end
            end
            ST_SIGN:
            begin
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    out_char_d = CH_MINUS;
                    state_next = ST_DIV_GO;
                end
            end
            ST_DIV_GO:
            begin
                div_req.start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    mag_next = div_rsp.quot;
                    if ((div_rsp.quot != '0) && (cnt_reg != CNT_W'(DIGIT_DEPTH - 1)))
                    begin
                        state_next = ST_DIV_GO;
                    end
                    else
                    begin
                        state_next = ST_POP_RD;
                    end
                end
            end
            ST_POP_RD:
            begin
                state_next = ST_TBL_RD;
            end
            ST_TBL_RD:
            begin
                cnt_next   = cnt_reg - CNT_W'(1);
                state_next = ST_EMIT;
            end
            ST_ZERO_RD:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    out_last_d = (cnt_reg == '0);
                    state_next = (cnt_reg == '0) ? ST_IDLE : ST_POP_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        last_char_next = last_char_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_char_next  = out_char_d;
            last_char_next = out_last_d;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            base_len_reg  <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_len_reg  <= base_len_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
        scan_reg      <= scan_next;
        mag_reg       <= mag_next;
        neg_reg       <= neg_next;
        out_char_reg  <= out_char_next;
        last_char_reg <= last_char_next;
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last_char = last_char_reg;

    `SIRT_ASSERT_NOW(a_ready_div_idle, in_ready, !div_rsp.busy, "input ready while divider busy")
    `SIRT_ASSERT_NOW(a_load_slot_free, out_load, slot_free, "output beat overwritten")
    `SIRT_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(DIGIT_DEPTH), "digit count overflow")
    `SIRT_ASSERT_NEXT(a_last_to_idle, out_load && out_last_d, state_reg == ST_IDLE, "no idle after last beat")

endmodule

>>> hw/rtl/sirt_divider.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sirt_divider
// Restoring divider, 32-bit dividend by 8-bit divisor, one quotient bit
// per cycle. Done pulses for one cycle with quotient and remainder valid.
// ---------------------------------------------------------------------------
module sirt_divider
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  sirt_pkg::sirt_div_req_t req,
    output sirt_pkg::sirt_div_rsp_t rsp
);
    import sirt_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_CW-1:0] step_reg, step_next;
    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [LEN_W-1:0]  dvs_reg, dvs_next;
    logic [LEN_W:0]    trial;
    logic              ge;

    always_comb
    begin
        trial = {rem_reg, quo_reg[NUM_W-1]};
        ge    = (trial >= {1'b0, dvs_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // the remainder stays below the divisor, so 8 bits hold it
            rem_next  = ge ? LEN_W'(trial - {1'b0, dvs_reg}) : trial[LEN_W-1:0];
            quo_next  = {quo_reg[NUM_W-2:0], ge};
            step_next = step_reg + DIV_CW'(1);
            if (step_reg == DIV_CW'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

>>> hw/rtl/sirt_sym_check.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sirt_sym_check
// Screens one digit symbol per call: printable range, no sign characters,
// and no repeat of a symbol already seen since the last clear.
// ---------------------------------------------------------------------------
module sirt_sym_check
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        clr,
    input  logic                        upd,
    input  logic [sirt_pkg::CHAR_W-1:0] sym,
    output logic                        bad
);
    import sirt_pkg::*;

    localparam int SEEN_N = 1 << CHAR_W;

    logic [SEEN_N-1:0] seen_reg, seen_next;

    assign bad = (sym < SYM_MIN) || (sym > SYM_MAX) || (sym == CH_MINUS)
              || (sym == CH_PLUS) || seen_reg[sym];

    always_comb
    begin
        seen_next = seen_reg;
        if (clr)
        begin
            seen_next = '0;
        end
        else if (upd)
        begin
            seen_next[sym] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
        end
        else
        begin
            seen_reg <= seen_next;
        end
    end

endmodule

>>> tb/sv/signed_int_to_custom_radix_text_top_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// signed_int_to_custom_radix_text_top_test
// Self-checking bench for the signed integer to radix text converter.
// ---------------------------------------------------------------------------
// Loads digit symbols and converts numbers through the input channel, and
// predicts every output character from a local copy of the symbol table and
// the length register. Covers the reset length, decimal, hex and binary,
// malformed bases, an output stall, a full table with the widest valid
// base and lengths past the table, then random phases with symbol swaps,
// noise loads and repairs under random idling on both channels.
// ---------------------------------------------------------------------------
module signed_int_to_custom_radix_text_top_test;
    import sirt_pkg::*;

    localparam int CLK_PERIOD   = 2;
    localparam int RESET_CYCLES = 12;
    localparam int DRAIN_CYCLES = 1300;
    localparam int STUCK_LIMIT  = 16000;
    localparam int IDLE_PCT     = 18;
    localparam int STALL_CYCLES = 1600;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } text_beat_t;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [LEN_W-1:0]         cfg_data  = '0;
    logic                     in_valid  = 1'b0;
    logic                     req_type  = REQ_LOAD;
    logic [TBL_AW-1:0]        sym_index = '0;
    logic [CHAR_W-1:0]        sym_char  = '0;
    logic signed [NUM_W-1:0]  number    = '0;
    logic                     out_ready = 1'b0;
    logic                     in_ready;
    logic                     out_valid;
    logic [CHAR_W-1:0]        out_char;
    logic                     last_char;

    // Local image of the block's symbol table and length register
    logic [CHAR_W-1:0] sym_tab [MAX_SYMBOLS];
    int unsigned       radix_len = 0;
    text_beat_t        expected_text [$];
    text_beat_t        want;

    int error_count   = 0;
    int stuck_cycles  = 0;
    int stall_request = 0;
    int stall_left    = 0;
    bit steady_tx     = 1'b0;
    bit steady_rx     = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    signed_int_to_custom_radix_text_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .sym_index (sym_index),
        .sym_char  (sym_char),
        .number    (number),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .last_char (last_char)
    );

    function automatic bit is_digit_symbol(input logic [CHAR_W-1:0] c);
        return c >= SYM_MIN && c <= SYM_MAX && c != CH_PLUS && c != CH_MINUS;
    endfunction

    function automatic bit radix_ok();
        int i;
        int j;
        if (radix_len < MIN_LEN || radix_len > MAX_SYMBOLS)
            return 1'b0;
        for (i = 0; i < radix_len; i++)
        begin
            if (!is_digit_symbol(sym_tab[i]))
                return 1'b0;
            for (j = i + 1; j < radix_len; j++)
                if (sym_tab[j] == sym_tab[i])
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    // Queue the characters that converting raw gives under the current base
    function automatic void predict_text(input logic [NUM_W-1:0] raw);
        logic [NUM_W-1:0] mag;
        int               digits [DIGIT_DEPTH];
        int               depth;
        int               k;
        depth = 0;
        if (!radix_ok())
            return;
        if (raw == '0)
        begin
            expected_text.push_back('{ch: sym_tab[0], last: 1'b1});
            return;
        end
        if (raw[NUM_W-1])
        begin
            mag = -raw;
            expected_text.push_back('{ch: CH_MINUS, last: 1'b0});
        end
        else
        begin
            mag = raw;
        end
        while (mag != 0 && depth < DIGIT_DEPTH)
        begin
            digits[depth] = mag % radix_len;
            mag = mag / radix_len;
            depth++;
        end
        for (k = depth - 1; k >= 0; k--)
            expected_text.push_back('{ch: sym_tab[digits[k]], last: (k == 0)});
    endfunction

    // Valid symbol not yet used in the live part of the table
    function automatic logic [CHAR_W-1:0] unused_symbol(input int slot);
        int                start;
        int                k;
        int                j;
        bit                taken;
        logic [CHAR_W-1:0] c;
        start = $urandom_range(SYM_MAX - SYM_MIN);
        for (k = 0; k <= SYM_MAX - SYM_MIN; k++)
        begin
            c = CHAR_W'(SYM_MIN + (start + k) % (SYM_MAX - SYM_MIN + 1));
            if (is_digit_symbol(c))
            begin
                taken = 1'b0;
                for (j = 0; j < radix_len; j++)
                    if (sym_tab[j] == c)
                        taken = 1'b1;
                if (!taken)
                    return c;
            end
        end
        return sym_tab[slot];
    endfunction

    function automatic logic [NUM_W-1:0] pick_number(input int unsigned len);
        logic [NUM_W-1:0] v;
        case ($urandom_range(9))
            0:
            begin
                case ($urandom_range(4))
                    0:       v = '0;
                    1:       v = '1;
                    2:       v = 1;
                    3:       v = 32'h7FFF_FFFF;
                    default: v = 32'h8000_0000;
                endcase
            end
            1, 2, 3:
            begin
                v = $urandom_range(len * len * len);
                if ($urandom_range(1))
                    v = -v;
            end
            default: v = $urandom();
        endcase
        return v;
    endfunction

    // Offer one beat, hold it until accepted, then update the prediction
    task automatic send_item(input logic rt, input logic [TBL_AW-1:0] idx,
                             input logic [CHAR_W-1:0] ch, input logic [NUM_W-1:0] num);
        int gap;
        if (!steady_tx && $urandom_range(99) < IDLE_PCT)
        begin
            gap = ($urandom_range(9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_type  <= rt;
        sym_index <= idx;
        sym_char  <= ch;
        number    <= num;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (rt == REQ_LOAD)
            sym_tab[idx] = ch;
        else
            predict_text(num);
    endtask

    task automatic send_load(input logic [TBL_AW-1:0] idx, input logic [CHAR_W-1:0] ch);
        send_item(REQ_LOAD, idx, ch, $urandom());
    endtask

    task automatic send_convert(input logic [NUM_W-1:0] num);
        send_item(REQ_CONVERT, TBL_AW'($urandom()), CHAR_W'($urandom()), num);
    endtask

    // Drain all output, let the block settle, then write the length
    task automatic set_radix_length(input int unsigned len);
        in_valid <= 1'b0;
        while (expected_text.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= len[LEN_W-1:0];
        @(posedge clk);
        cfg_we   <= 1'b0;
        radix_len = len;
    endtask

    // Replace bad or repeated symbols in the live part of the table
    task automatic mend_radix();
        int i;
        int j;
        bit bad;
        for (i = 0; i < radix_len; i++)
        begin
            bad = !is_digit_symbol(sym_tab[i]);
            for (j = 0; j < i; j++)
                if (sym_tab[j] == sym_tab[i])
                    bad = 1'b1;
            if (bad)
                send_load(TBL_AW'(i), unused_symbol(i));
        end
    endtask

    task automatic test_after_reset();
        set_radix_length(0);
        send_convert('0);
        send_convert(32'h8000_0000);
    endtask

    task automatic test_known_radixes();
        string hex_digits;
        int    i;
        hex_digits = "0123456789ABCDEF";
        for (i = 0; i < 16; i++)
            send_load(TBL_AW'(i), hex_digits[i]);
        set_radix_length(10);
        send_convert('0);
        send_convert(1);
        send_convert('1);
        send_convert(32'h7FFF_FFFF);
        send_convert(32'h8000_0000);
        send_convert(-10);
        set_radix_length(16);
        send_convert(32'hDEAD_BEEF);
        send_convert(32'h7FFF_FFFF);
        set_radix_length(2);
        send_convert(32'h8000_0000);
        send_convert(5);
    endtask

    task automatic test_bad_radixes();
        set_radix_length(1);
        send_convert(7);
        set_radix_length(10);
        send_load(3, CH_PLUS);
        send_convert(42);
        send_load(3, CH_MINUS);
        send_convert(42);
        send_load(3, SYM_MIN - 8'd1);
        send_convert(42);
        send_load(3, SYM_MAX + 8'd1);
        send_convert(42);
        send_load(3, 8'h00);
        send_convert(42);
        send_load(3, 8'hFF);
        send_convert(42);
        // repeat entry 7 in slot 3
        send_load(3, sym_tab[7]);
        send_convert(42);
        send_load(3, SYM_MIN);
        send_convert(3);
        send_load(9, SYM_MAX);
        send_convert(-99);
        send_load(3, "3");
        send_load(9, "9");
        send_convert(123);
    endtask

    // Hold off the output while the sender keeps offering long conversions
    task automatic test_output_stall();
        set_radix_length(2);
        steady_tx = 1'b1;
        stall_request = STALL_CYCLES;
        send_convert(32'h8000_0000);
        send_convert(32'h7FFF_FFFF);
        send_convert('1);
        send_convert(32'h5555_5555);
        steady_tx = 1'b0;
    endtask

    task automatic test_full_table();
        logic [CHAR_W-1:0] pool [$];
        logic [CHAR_W-1:0] tmp;
        int                i;
        int                j;
        int                c;
        for (c = SYM_MIN; c <= SYM_MAX; c++)
            if (is_digit_symbol(CHAR_W'(c)))
                pool.push_back(CHAR_W'(c));
        for (i = pool.size() - 1; i > 0; i--)
        begin
            j = $urandom_range(i);
            tmp = pool[i];
            pool[i] = pool[j];
            pool[j] = tmp;
        end
        for (i = 0; i < MAX_SYMBOLS; i++)
            send_load(TBL_AW'(i),
                      (i < pool.size()) ? pool[i] : CHAR_W'($urandom_range(255)));
        // widest base that can be valid
        set_radix_length(pool.size());
        send_convert(32'h8000_0000);
        send_convert(32'h7FFF_FFFF);
        repeat (3) send_convert(pick_number(radix_len));
        set_radix_length(MAX_SYMBOLS);
        repeat (2) send_convert($urandom());
        set_radix_length(MAX_SYMBOLS + 1);
        send_convert($urandom());
        set_radix_length((1 << LEN_W) - 1);
        send_convert($urandom());
    endtask

    task automatic test_random_text();
        int          phase;
        int          roll;
        int          slot;
        int unsigned len;
        for (phase = 0; phase < 7; phase++)
        begin
            roll = $urandom_range(9);
            if (roll < 2)
                len = $urandom_range(2, 3);
            else if (roll < 7)
                len = $urandom_range(4, 16);
            else if (roll < 9)
                len = $urandom_range(17, 40);
            else
                len = $urandom_range(41, 92);
            set_radix_length(len);
            // one phase runs with no idling on either side
            steady_tx = (phase == 3);
            steady_rx = (phase == 3);
            mend_radix();
            repeat (12)
            begin
                roll = $urandom_range(99);
                if (roll < 68)
                begin
                    send_convert(pick_number(radix_len));
                end
                else if (roll < 85)
                begin
                    slot = $urandom_range(radix_len - 1);
                    send_load(TBL_AW'(slot), unused_symbol(slot));
                end
                else if (roll < 95)
                begin
                    send_load(TBL_AW'($urandom_range(MAX_SYMBOLS - 1)),
                              CHAR_W'($urandom_range(255)));
                end
                else
                begin
                    mend_radix();
                end
            end
        end
        steady_tx = 1'b0;
        steady_rx = 1'b0;
    endtask

    // Output side: check each beat, then pick the next ready
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_text.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected beat, expected none, actual char %h last %b",
                         $time, out_char, last_char);
            end
            else
            begin
                want = expected_text.pop_front();
                if (out_char !== want.ch)
                begin
                    error_count++;
                    $display("%0t: out_char expected %h actual %h", $time, want.ch, out_char);
                end
                if (last_char !== want.last)
                begin
                    error_count++;
                    $display("%0t: last_char expected %b actual %b",
                             $time, want.last, last_char);
                end
            end
        end
        if (stall_request > 0)
        begin
            stall_left = stall_request;
            stall_request = 0;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (steady_rx)
        begin
            out_ready <= 1'b1;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // End the run if no beat moves on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            stuck_cycles = 0;
        end
        else
        begin
            stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_after_reset();
        test_known_radixes();
        test_bad_radixes();
        test_output_stall();
        test_full_table();
        test_random_text();
        in_valid <= 1'b0;
        while (expected_text.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
